>>> src/dfk_pkg.sv
// shared constants, segment codes and controller/datapath interface types
`timescale 1ns / 1ps

package dfk_pkg;

  // stream payload widths
  localparam int InDataW  = 480;
  localparam int OutDataW = 128;
  localparam int UserW    = 2;
  localparam int CfgW     = 32;

  // input tdata field offsets, lowest bit of each field
  localparam int OffKind  = 0;
  localparam int OffX     = 32;
  localparam int OffZ     = 96;
  localparam int OffSfp   = 160;
  localparam int OffArev  = 224;
  localparam int OffSrev  = 288;
  localparam int OffPlen  = 352;
  localparam int OffDcnt  = 360;
  localparam int OffPbyte = 376;
  localparam int OffDom   = 384;
  localparam int OffRev   = 416;

  // hash constants
  localparam logic [63:0] PrimeA    = 64'd1099511628211;
  localparam logic [63:0] PrimeB    = 64'd14029467366897019727;
  localparam logic [63:0] SeedHi    = 64'd14695981039346656037;
  localparam logic [63:0] SeedLo    = 64'd7809847782465536322;
  localparam logic [63:0] DepSeedHi = 64'hcbf29ce484222325;
  localparam logic [63:0] DepSeedLo = 64'h6c62272e07bb0142;

  // request kinds carried in tuser
  localparam logic [1:0] REQ_HDR  = 2'd0;
  localparam logic [1:0] REQ_PROF = 2'd1;
  localparam logic [1:0] REQ_DEP  = 2'd2;

  // byte segment sources
  localparam logic [3:0] SEG_KIND  = 4'd0;
  localparam logic [3:0] SEG_CVER  = 4'd1;
  localparam logic [3:0] SEG_X     = 4'd2;
  localparam logic [3:0] SEG_Z     = 4'd3;
  localparam logic [3:0] SEG_SFP   = 4'd4;
  localparam logic [3:0] SEG_AREV  = 4'd5;
  localparam logic [3:0] SEG_SREV  = 4'd6;
  localparam logic [3:0] SEG_PLEN  = 4'd7;
  localparam logic [3:0] SEG_DCNT  = 4'd8;
  localparam logic [3:0] SEG_PBYTE = 4'd9;
  localparam logic [3:0] SEG_DX    = 4'd10;
  localparam logic [3:0] SEG_DZ    = 4'd11;
  localparam logic [3:0] SEG_DOM   = 4'd12;
  localparam logic [3:0] SEG_REV   = 4'd13;
  localparam logic [3:0] SEG_XOR   = 4'd14;
  localparam logic [3:0] SEG_SUM   = 4'd15;

  typedef struct packed {
    logic       capture;
    logic       start_hdr;
    logic       start_dep;
    logic       load_src;
    logic [3:0] src_sel;
    logic       mul_a;
    logic       mul_b;
    logic       fp_tgt;
    logic       dec_bytes;
    logic       dec_deps;
    logic       acc;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic bytes_zero;
    logic deps_zero;
  } sts_t;

endpackage

>>> src/dfk_datapath.sv
// hash lanes, operand hold, counters and result register
`timescale 1ns / 1ps

module dfk_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dfk_pkg::cmd_t                 cmd,
  output dfk_pkg::sts_t                 sts,
  input  logic [dfk_pkg::InDataW-1:0]   in_tdata,
  input  logic                          cfg_wr,
  input  logic [dfk_pkg::CfgW-1:0]      cfg_data,
  output logic [dfk_pkg::OutDataW-1:0]  out_tdata
);

  logic [dfk_pkg::InDataW-1:0] hold_r;
  logic [31:0] cver_r;
  logic [63:0] hash_hi_r, hash_lo_r, fp_hi_r, fp_lo_r;
  logic [63:0] xor_hi_r, sum_hi_r, xor_lo_r, sum_lo_r;
  logic        invalid_r;
  logic [7:0]  bytes_left_r;
  logic [15:0] deps_left_r;
  logic [63:0] src_r, src_nxt;
  logic [63:0] src_lo_r;
  logic [63:0] p0_r [2];
  logic [31:0] p1_r [2];
  logic [7:0]  lane_b [2];
  logic [63:0] lane_h [2];
  logic [63:0] lane_p [2];
  logic [63:0] lane_x [2];
  logic [63:0] lane_p0 [2];
  logic [31:0] lane_p1 [2];
  logic [63:0] lane_new [2];
  logic [63:0] key_hi_r, key_lo_r;

  // held fields
  logic [31:0] f_kind, f_dom;
  logic [63:0] f_x, f_z, f_sfp, f_arev, f_srev, f_rev;
  logic [7:0]  f_plen, f_pbyte;
  logic [15:0] f_dcnt;

  assign f_kind  = hold_r[dfk_pkg::OffKind +: 32];
  assign f_x     = hold_r[dfk_pkg::OffX +: 64];
  assign f_z     = hold_r[dfk_pkg::OffZ +: 64];
  assign f_sfp   = hold_r[dfk_pkg::OffSfp +: 64];
  assign f_arev  = hold_r[dfk_pkg::OffArev +: 64];
  assign f_srev  = hold_r[dfk_pkg::OffSrev +: 64];
  assign f_plen  = hold_r[dfk_pkg::OffPlen +: 8];
  assign f_dcnt  = hold_r[dfk_pkg::OffDcnt +: 16];
  assign f_pbyte = hold_r[dfk_pkg::OffPbyte +: 8];
  assign f_dom   = hold_r[dfk_pkg::OffDom +: 32];
  assign f_rev   = hold_r[dfk_pkg::OffRev +: 64];

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cver_r <= 32'd1;
    end else if (cfg_wr) begin
      cver_r <= cfg_data;
    end
  end

  // input beat hold
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hold_r <= in_tdata;
    end
  end

  // byte source select
  always_comb begin
    case (cmd.src_sel) inside
      dfk_pkg::SEG_KIND:               src_nxt = {32'd0, f_kind};
      dfk_pkg::SEG_CVER:               src_nxt = {32'd0, cver_r};
      dfk_pkg::SEG_X, dfk_pkg::SEG_DX: src_nxt = f_x;
      dfk_pkg::SEG_Z, dfk_pkg::SEG_DZ: src_nxt = f_z;
      dfk_pkg::SEG_SFP:                src_nxt = f_sfp;
      dfk_pkg::SEG_AREV:               src_nxt = f_arev;
      dfk_pkg::SEG_SREV:               src_nxt = f_srev;
      dfk_pkg::SEG_PLEN:               src_nxt = {56'd0, bytes_left_r};
      dfk_pkg::SEG_DCNT:               src_nxt = {48'd0, deps_left_r};
      dfk_pkg::SEG_PBYTE:              src_nxt = {56'd0, f_pbyte};
      dfk_pkg::SEG_DOM:                src_nxt = {32'd0, f_dom};
      dfk_pkg::SEG_REV:                src_nxt = f_rev;
      dfk_pkg::SEG_XOR:                src_nxt = xor_hi_r;
      default:                         src_nxt = sum_hi_r;
    endcase
  end

  // byte shift registers; the low lane has its own xor and sum segments
  always_ff @(posedge clk) begin
    if (cmd.load_src) begin
      src_r    <= src_nxt;
      src_lo_r <= (cmd.src_sel == dfk_pkg::SEG_XOR) ? xor_lo_r :
                  (cmd.src_sel == dfk_pkg::SEG_SUM) ? sum_lo_r : src_nxt;
    end else if (cmd.mul_b) begin
      src_r    <= src_r >> 8;
      src_lo_r <= src_lo_r >> 8;
    end
  end

  // lane operand select: main chains or dependency prints
  always_comb begin
    lane_b[0] = src_r[7:0];
    lane_b[1] = src_lo_r[7:0];
    lane_h[0] = cmd.fp_tgt ? fp_hi_r : hash_hi_r;
    lane_h[1] = cmd.fp_tgt ? fp_lo_r : hash_lo_r;
    lane_p[0] = dfk_pkg::PrimeA;
    lane_p[1] = cmd.fp_tgt ? dfk_pkg::PrimeA : dfk_pkg::PrimeB;
  end

  // xor byte then split 64x64 low product into partial products of 32-bit halves
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      lane_x[i]   = lane_h[i] ^ {56'd0, lane_b[i]};
      lane_p0[i]  = lane_x[i][31:0] * lane_p[i][31:0];
      lane_p1[i]  = lane_x[i][31:0] * lane_p[i][63:32] + lane_x[i][63:32] * lane_p[i][31:0];
      lane_new[i] = p0_r[i] + {p1_r[i], 32'd0};
    end
  end

  // partial product registers
  always_ff @(posedge clk) begin
    if (cmd.mul_a) begin
      for (int i = 0; i < 2; i++) begin
        p0_r[i] <= lane_p0[i];
        p1_r[i] <= lane_p1[i];
      end
    end
  end

  // hash chain state
  always_ff @(posedge clk) begin
    if (cmd.start_hdr) begin
      hash_hi_r <= dfk_pkg::SeedHi;
      hash_lo_r <= dfk_pkg::SeedLo;
      xor_hi_r  <= '0;
      sum_hi_r  <= '0;
      xor_lo_r  <= '0;
      sum_lo_r  <= '0;
      invalid_r <= (f_sfp == 64'd0) || (f_arev == 64'd0) || (cver_r == 32'd0);
    end else if (cmd.acc) begin
      xor_hi_r <= xor_hi_r ^ fp_hi_r;
      sum_hi_r <= sum_hi_r + fp_hi_r;
      xor_lo_r <= xor_lo_r ^ fp_lo_r;
      sum_lo_r <= sum_lo_r + fp_lo_r;
    end else if (cmd.mul_b && !cmd.fp_tgt) begin
      hash_hi_r <= lane_new[0];
      hash_lo_r <= lane_new[1];
    end
    if (cmd.start_dep) begin
      fp_hi_r <= dfk_pkg::DepSeedHi;
      fp_lo_r <= dfk_pkg::DepSeedLo;
    end else if (cmd.mul_b && cmd.fp_tgt) begin
      fp_hi_r <= lane_new[0];
      fp_lo_r <= lane_new[1];
    end
  end

  // item counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
      deps_left_r  <= '0;
    end else begin
      if (cmd.start_hdr) begin
        bytes_left_r <= f_plen;
        deps_left_r  <= f_dcnt;
      end else begin
        if (cmd.dec_bytes) begin
          bytes_left_r <= bytes_left_r - 8'd1;
        end
        if (cmd.dec_deps) begin
          deps_left_r <= deps_left_r - 16'd1;
        end
      end
    end
  end

  assign sts.bytes_zero = (bytes_left_r == 8'd0);
  assign sts.deps_zero  = (deps_left_r == 16'd0);

  // result register with invalid and zero key rules
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (invalid_r) begin
        key_hi_r <= '0;
        key_lo_r <= '0;
      end else if (hash_hi_r == 64'd0 && hash_lo_r == 64'd0) begin
        key_hi_r <= '0;
        key_lo_r <= 64'd1;
      end else begin
        key_hi_r <= hash_hi_r;
        key_lo_r <= hash_lo_r;
      end
    end
  end

  assign out_tdata = {key_lo_r, key_hi_r};

endmodule

>>> src/dfk_ctrl.sv
// sequencer: message phase, byte segments and result handshake
`timescale 1ns / 1ps

module dfk_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [dfk_pkg::UserW-1:0] in_tuser,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  input  dfk_pkg::sts_t             sts,
  output dfk_pkg::cmd_t             cmd
);

  localparam logic [2:0] S_WAIT = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_MULA = 3'd3;
  localparam logic [2:0] S_MULB = 3'd4;
  localparam logic [2:0] S_ACC  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PROF = 2'd1;
  localparam logic [1:0] PH_DEPS = 2'd2;

  logic [2:0] state_r, state_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic [1:0] req_r, req_nxt;
  logic [3:0] seg_r, seg_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       fp_seg;

  assign in_tready  = (state_r == S_WAIT);
  assign out_tvalid = out_valid_r;
  assign fp_seg = (seg_r == dfk_pkg::SEG_DX) || (seg_r == dfk_pkg::SEG_DZ) ||
                  (seg_r == dfk_pkg::SEG_DOM) || (seg_r == dfk_pkg::SEG_REV);

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    req_nxt       = req_r;
    seg_nxt       = seg_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.src_sel   = seg_r;
    cmd.fp_tgt    = fp_seg;
    unique case (state_r)
      S_WAIT: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          req_nxt     = in_tuser;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_WAIT;
        if (req_r == dfk_pkg::REQ_HDR && ph_r == PH_IDLE) begin
          cmd.start_hdr = 1'b1;
          seg_nxt       = dfk_pkg::SEG_KIND;
          state_nxt     = S_LOAD;
        end else if (req_r == dfk_pkg::REQ_PROF && ph_r == PH_PROF) begin
          cmd.dec_bytes = 1'b1;
          seg_nxt       = dfk_pkg::SEG_PBYTE;
          state_nxt     = S_LOAD;
        end else if (req_r == dfk_pkg::REQ_DEP && ph_r == PH_DEPS) begin
          cmd.start_dep = 1'b1;
          cmd.dec_deps  = 1'b1;
          seg_nxt       = dfk_pkg::SEG_DX;
          state_nxt     = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load_src = 1'b1;
        if (seg_r == dfk_pkg::SEG_KIND || seg_r == dfk_pkg::SEG_CVER ||
            seg_r == dfk_pkg::SEG_DOM) begin
          cnt_nxt = 4'd4;
        end else if (seg_r == dfk_pkg::SEG_PBYTE) begin
          cnt_nxt = 4'd1;
        end else begin
          cnt_nxt = 4'd8;
        end
        state_nxt = S_MULA;
      end
      S_MULA: begin
        cmd.mul_a = 1'b1;
        state_nxt = S_MULB;
      end
      S_MULB: begin
        cmd.mul_b = 1'b1;
        cnt_nxt   = cnt_r - 4'd1;
        if (cnt_r != 4'd1) begin
          state_nxt = S_MULA;
        end else begin
          // segment done: pick the next one or close the step
          state_nxt = S_LOAD;
          case (seg_r)
            dfk_pkg::SEG_KIND:  seg_nxt = dfk_pkg::SEG_CVER;
            dfk_pkg::SEG_CVER:  seg_nxt = dfk_pkg::SEG_X;
            dfk_pkg::SEG_X:     seg_nxt = dfk_pkg::SEG_Z;
            dfk_pkg::SEG_Z:     seg_nxt = dfk_pkg::SEG_SFP;
            dfk_pkg::SEG_SFP:   seg_nxt = dfk_pkg::SEG_AREV;
            dfk_pkg::SEG_AREV:  seg_nxt = dfk_pkg::SEG_SREV;
            dfk_pkg::SEG_SREV:  seg_nxt = dfk_pkg::SEG_PLEN;
            dfk_pkg::SEG_DX:    seg_nxt = dfk_pkg::SEG_DZ;
            dfk_pkg::SEG_DZ:    seg_nxt = dfk_pkg::SEG_DOM;
            dfk_pkg::SEG_DOM:   seg_nxt = dfk_pkg::SEG_REV;
            dfk_pkg::SEG_REV:   state_nxt = S_ACC;
            dfk_pkg::SEG_XOR:   seg_nxt = dfk_pkg::SEG_SUM;
            dfk_pkg::SEG_SUM:   state_nxt = S_EMIT;
            dfk_pkg::SEG_DCNT: begin
              if (sts.deps_zero) begin
                seg_nxt = dfk_pkg::SEG_XOR;
              end else begin
                ph_nxt    = PH_DEPS;
                state_nxt = S_WAIT;
              end
            end
            default: begin
              // header length or profile byte finished
              if (sts.bytes_zero) begin
                seg_nxt = dfk_pkg::SEG_DCNT;
              end else begin
                ph_nxt    = PH_PROF;
                state_nxt = S_WAIT;
              end
            end
          endcase
        end
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (sts.deps_zero) begin
          seg_nxt   = dfk_pkg::SEG_XOR;
          state_nxt = S_LOAD;
        end else begin
          state_nxt = S_WAIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          ph_nxt        = PH_IDLE;
          state_nxt     = S_WAIT;
        end
      end
      default: state_nxt = S_WAIT;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_WAIT;
      ph_r        <= PH_IDLE;
      req_r       <= '0;
      seg_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      req_r       <= req_nxt;
      seg_r       <= seg_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  // result register is only overwritten once its beat is gone
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("result overwritten while pending");

  // one datapath action at a time
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.mul_a, cmd.mul_b, cmd.load_src, cmd.acc, cmd.load_out}))
    else $error("conflicting datapath commands");

  // accepted beat is dispatched next cycle
  a_disp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_DISP))
    else $error("accepted beat not dispatched");

  // byte counter live while multiplying
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MULA || state_r == S_MULB) |-> (cnt_r != 4'd0))
    else $error("byte counter empty during multiply");
`endif

endmodule

>>> src/dual_fnv_content_key_hash_core.sv
// top level of the dual fnv content key hasher
`timescale 1ns / 1ps

// channel   dir  handshake            payload
// in_       in   in_tvalid/in_tready  in_tdata 480b, in_tuser 2b request kind
// out_      out  out_tvalid/out_tready out_tdata 128b content key
// cfg_      in   cfg_valid/cfg_ready  cfg_data 32b compiler version
//
// every hashed byte goes through the split 64-bit multiply of each lane, partial products then sum
// a new beat is accepted only once the previous beat's step is done
// the last beat of a key adds xor, sum and emit (and count if no dependencies) before the key is registered
// synchronous active-low reset; compiler version resets to 1
// a key waiting on out_tready stalls the block only at the next key's emit step

module dual_fnv_content_key_hash_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // kind[31:0] x[95:32] z[159:96] sfp[223:160] arev[287:224] srev[351:288]
  // plen[359:352] dcnt[375:360] pbyte[383:376] dom[415:384] rev[479:416]
  input  logic [479:0] in_tdata,
  // req_type[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // key_high[63:0] key_low[127:64]
  output logic [127:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data
);

  dfk_pkg::cmd_t cmd;
  dfk_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  dfk_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  dfk_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .cfg_wr    (cfg_valid),
    .cfg_data  (cfg_data),
    .out_tdata (out_tdata)
  );

endmodule
